// ===== rtl/tdma_pkg.sv =====
// Shared constants, widths and control types of the time-of-day moving average core.
`default_nettype none

package tdma_pkg;

   // Deepest window the ring store holds
   localparam int MAX_WINDOW = 64;

   // Fixed field widths
   localparam int START_W   = 1;
   localparam int HOURS_W   = 5;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;
   localparam int CFG_W     = 7;
   localparam int STAMP_W   = 17;

   // Widths that follow from the window depth
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = STAMP_W + SLOT_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam int HOUR_SECONDS   = 3600;
   localparam int MINUTE_SECONDS = 60;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic cfg_write;
      logic update;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic window_full;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/tdma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tdma_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tdma_datapath.sv =====
// Datapath: stamp conversion, window ring and running sum, serial divider, result register.
`default_nettype none

module tdma_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tdma_pkg::ctrl_cmd_type          cmd,
   output tdma_pkg::dp_status_type              status,
   input  wire logic [tdma_pkg::START_W-1:0]    req_start_series,
   input  wire logic [tdma_pkg::HOURS_W-1:0]    req_hours,
   input  wire logic [tdma_pkg::MINUTES_W-1:0]  req_minutes,
   input  wire logic [tdma_pkg::SECONDS_W-1:0]  req_seconds_part,
   input  wire logic [tdma_pkg::CFG_W-1:0]      csr_window_length,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic [tdma_pkg::STAMP_W-1:0]         rsp_average_seconds
);

   import tdma_pkg::*;

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]  cur_slot_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAMP_W-1:0] rsp_data_ff;

   logic [STAMP_W-1:0] stamp_calc;
   logic [SLOT_W-1:0]  slot_pick;
   logic [STAMP_W-1:0] old_stamp;
   logic               full_now;
   logic [SUM_W-1:0]   sum_next;
   logic [LEN_W-1:0]   fill_inc;
   logic [LEN_W-1:0]   slot_inc;
   logic [LEN_W:0]     trial;
   logic [STAMP_W-1:0] rd_data;

   // Seconds of the day from the raw fields
   assign stamp_calc = STAMP_W'(req_hours) * STAMP_W'(HOUR_SECONDS)
                     + STAMP_W'(req_minutes) * STAMP_W'(MINUTE_SECONDS)
                     + STAMP_W'(req_seconds_part);

   // A new series starts at slot zero; otherwise guard the ring index
   always_comb begin
      if (req_start_series[0]) begin
         slot_pick = '0;
      end else if (LEN_W'(write_slot_ff) >= len_ff) begin
         slot_pick = '0;
      end else begin
         slot_pick = write_slot_ff;
      end
   end

   assign full_now  = (fill_ff >= len_ff);
   assign old_stamp = full_now ? rd_data : '0;
   assign sum_next  = sum_ff - SUM_W'(old_stamp) + SUM_W'(stamp_ff);
   assign fill_inc  = fill_ff + LEN_W'(1);
   assign slot_inc  = LEN_W'(cur_slot_ff) + LEN_W'(1);
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};

   assign status.window_full = full_now || (fill_inc >= len_ff);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   tdma_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (cur_slot_ff),
      .wr_data (stamp_ff),
      .rd_en   (cmd.accept),
      .rd_addr (slot_pick),
      .rd_data (rd_data)
   );

   always_comb begin
      len_in        = len_ff;
      sum_in        = sum_ff;
      fill_in       = fill_ff;
      write_slot_in = write_slot_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.cfg_write) begin
         if (csr_window_length == '0) begin
            len_in = LEN_W'(1);
         end else if (32'(csr_window_length) > 32'(MAX_WINDOW)) begin
            len_in = LEN_W'(MAX_WINDOW);
         end else begin
            len_in = LEN_W'(csr_window_length);
         end
         sum_in        = '0;
         fill_in       = '0;
         write_slot_in = '0;
      end

      if (cmd.accept && req_start_series[0]) begin
         sum_in  = '0;
         fill_in = '0;
      end

      if (cmd.update) begin
         sum_in  = sum_next;
         fill_in = full_now ? fill_ff : fill_inc;
         write_slot_in = (slot_inc >= len_ff) ? '0 : slot_inc[SLOT_W-1:0];
         quo_in  = sum_next;
         rem_in  = '0;
      end

      // One quotient bit per step, restoring
      if (cmd.div_step) begin
         if (trial >= {1'b0, len_ff}) begin
            rem_in = LEN_W'(trial - {1'b0, len_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= LEN_W'(1);
         sum_ff        <= '0;
         fill_ff       <= '0;
         write_slot_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         fill_ff       <= fill_in;
         write_slot_ff <= write_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.accept) begin
         stamp_ff    <= stamp_calc;
         cur_slot_ff <= slot_pick;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= quo_ff[STAMP_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average_seconds = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tdma_ctrl.sv =====
// Controller: sequences accept, window update, serial divide and result load.
`default_nettype none

module tdma_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   csr_valid,
   input  wire tdma_pkg::dp_status_type status,
   output tdma_pkg::ctrl_cmd_type      cmd,
   output logic                        req_stall,
   output logic                        csr_ready
);

   import tdma_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            // A register write takes the cycle; hold the input word
            req_stall = csr_valid;
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.window_full) begin
               count_in = DIV_CNT_W'(SUM_W - 1);
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (count_ff == '0) begin
               state_in = ST_OUTPUT;
            end else begin
               count_in = count_ff - DIV_CNT_W'(1);
            end
         end
         ST_OUTPUT: begin
            // Wait until the previous result word is taken
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/time_of_day_moving_average_core.sv =====
// Top level of the time-of-day moving average core.
//
//   channel  direction  handshake          payload
//   req      in         valid / stall      start_series, hours, minutes, seconds_part
//   rsp      out        valid / stall      average_seconds
//   csr      in         valid / ready      window_length
//
// An item that leaves the window short of full passes through accept and ring update.
// A full window adds the serial divider, one quotient bit per step (SUM_W, 23 by
// default), and then loads the result register.
// Reset is synchronous; it sets the window length to 1 and empties the series.
// The result register frees the divider: the next word is accepted while a result waits.
// A result that is still stalled when the next quotient is ready holds the controller.
`default_nettype none

module time_of_day_moving_average_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [tdma_pkg::START_W-1:0]    req_start_series,
   input  wire logic [tdma_pkg::HOURS_W-1:0]    req_hours,
   input  wire logic [tdma_pkg::MINUTES_W-1:0]  req_minutes,
   input  wire logic [tdma_pkg::SECONDS_W-1:0]  req_seconds_part,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [tdma_pkg::STAMP_W-1:0]         rsp_average_seconds,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tdma_pkg::CFG_W-1:0]      csr_window_length
);

   import tdma_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tdma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .csr_ready (csr_ready)
   );

   tdma_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_start_series    (req_start_series),
      .req_hours           (req_hours),
      .req_minutes         (req_minutes),
      .req_seconds_part    (req_seconds_part),
      .csr_window_length   (csr_window_length),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_average_seconds (rsp_average_seconds)
   );

endmodule

`default_nettype wire
